[sv/rds_pkg.sv]
package rds_pkg;

  // Frame geometry and digit range.
  localparam int COLUMNS    = 12;
  localparam int ROWS       = 16;
  localparam int DIGITS     = 10;
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int DIGIT_W    = 4;
  localparam int OFFSET_W   = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [DIGIT_W-1:0] LAST_DIGIT = DIGIT_W'(DIGITS - 1);
  localparam logic [COL_W-1:0]   LAST_COL   = COL_W'(COLUMNS - 1);

  // Function codes on the request channel.
  localparam logic [1:0] FUNC_SCROLL = 2'd0;
  localparam logic [1:0] FUNC_SET    = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  // Decoded operation handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_UP,
    OP_DOWN,
    OP_SET,
    OP_READ,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [DIGIT_W-1:0] digit;
  } cmd_t;

  // Digit glyphs, one 16-dot word per column, bit 15 at the top.
  localparam logic [ROWS-1:0] GLYPH_ROM [DIGITS][COLUMNS] = '{
    '{16'h0000, 16'h0000, 16'h3ff0, 16'h3ff0, 16'hc0cc, 16'hc0cc,
      16'hc30c, 16'hc30c, 16'hcc0c, 16'hcc0c, 16'h3ff0, 16'h3ff0},
    '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h300c, 16'h300c,
      16'hfffc, 16'hfffc, 16'h000c, 16'h000c, 16'h0000, 16'h0000},
    '{16'h0000, 16'h0000, 16'h300c, 16'h300c, 16'hc03c, 16'hc03c,
      16'hc0cc, 16'hc0cc, 16'hc30c, 16'hc30c, 16'h3c0c, 16'h3c0c},
    '{16'h0000, 16'h0000, 16'hc030, 16'hc030, 16'hc00c, 16'hc00c,
      16'hcc0c, 16'hcc0c, 16'hf30c, 16'hf30c, 16'hc0f0, 16'hc0f0},
    '{16'h0000, 16'h0000, 16'h03c0, 16'h03c0, 16'h0cc0, 16'h0cc0,
      16'h30c0, 16'h30c0, 16'hfffc, 16'hfffc, 16'h00c0, 16'h00c0},
    '{16'h0000, 16'h0000, 16'hfc30, 16'hfc30, 16'hcc0c, 16'hcc0c,
      16'hcc0c, 16'hcc0c, 16'hcc0c, 16'hcc0c, 16'hc3f0, 16'hc3f0},
    '{16'h0000, 16'h0000, 16'h0ff0, 16'h0ff0, 16'h330c, 16'h330c,
      16'hc30c, 16'hc30c, 16'hc30c, 16'hc30c, 16'h00f0, 16'h00f0},
    '{16'h0000, 16'h0000, 16'hc000, 16'hc000, 16'hc0fc, 16'hc0fc,
      16'hc300, 16'hc300, 16'hcc00, 16'hcc00, 16'hf000, 16'hf000},
    '{16'h0000, 16'h0000, 16'h3cf0, 16'h3cf0, 16'hc30c, 16'hc30c,
      16'hc30c, 16'hc30c, 16'hc30c, 16'hc30c, 16'h3cf0, 16'h3cf0},
    '{16'h0000, 16'h0000, 16'h3c00, 16'h3c00, 16'hc30c, 16'hc30c,
      16'hc30c, 16'hc30c, 16'hc330, 16'hc330, 16'h3fc0, 16'h3fc0}
  };

  // Glyph column lookup; codes above nine fall back to digit zero.
  function automatic logic [ROWS-1:0] glyph_word(input logic [DIGIT_W-1:0] d,
                                                 input int c);
    logic [ROWS-1:0] w;
    w = GLYPH_ROM[0][c];
    if (d <= LAST_DIGIT) begin
      w = GLYPH_ROM[d][c];
    end
    return w;
  endfunction

  // Single dot of a glyph column, row zero at the bottom.
  function automatic logic glyph_bit(input logic [DIGIT_W-1:0] d, input int c,
                                     input logic [ROW_W-1:0] r);
    logic [ROWS-1:0] w;
    w = glyph_word(d, c);
    return w[r];
  endfunction

endpackage

[sv/rds_front.sv]
module rds_front
  import rds_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic               in_direction,
  input  logic [DIGIT_W-1:0] in_digit,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output cmd_t               cmd
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             queue [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  cmd_t             decoded;
  logic             push;
  logic             pop;

  // Classify the incoming request into an operation for the back end.
  always_comb begin
    decoded.digit = in_digit;
    case (in_func)
      FUNC_SCROLL: decoded.op = in_direction ? OP_DOWN : OP_UP;
      FUNC_SET: begin
        if (in_digit inside {[4'd0:LAST_DIGIT]}) begin
          decoded.op = OP_SET;
        end else begin
          decoded.op = OP_NOP;
        end
      end
      FUNC_READ: decoded.op = OP_READ;
      default:   decoded.op = OP_NOP;
    endcase
  end

  // Queue handshakes.
  assign in_ready  = (count != CNT_W'(QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  // Queue entries carry no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= decoded;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

endmodule

[sv/rds_back.sv]
module rds_back
  import rds_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  cmd_t                cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COL_W-1:0]    out_col,
  output logic [ROWS-1:0]     out_pix,
  output logic [DIGIT_W-1:0]  out_digit,
  output logic [OFFSET_W-1:0] out_offset,
  output logic                out_last
);

  logic [ROWS-1:0]            frame [COLUMNS];
  logic [ROWS-1:0]            frame_next [COLUMNS];
  logic [DIGIT_W-1:0]         digit;
  logic [DIGIT_W-1:0]         digit_next;
  logic signed [OFFSET_W-1:0] offset;
  logic signed [OFFSET_W-1:0] offset_next;
  logic                       busy;
  logic [COL_W-1:0]           col_cnt;
  logic                       out_free;
  logic                       take;
  logic [DIGIT_W-1:0]         inc_digit;
  logic [DIGIT_W-1:0]         dec_digit;
  logic [DIGIT_W-1:0]         src_digit;
  logic [ROW_W-1:0]           row;
  logic signed [OFFSET_W-1:0] neg_offset;

  assign out_free  = !out_valid || out_ready;
  assign cmd_ready = !busy && out_free;
  assign take      = cmd_valid && cmd_ready;

  assign inc_digit  = (digit == LAST_DIGIT) ? '0 : DIGIT_W'(digit + 1'b1);
  assign dec_digit  = (digit == '0) ? LAST_DIGIT : DIGIT_W'(digit - 1'b1);
  assign neg_offset = OFFSET_W'(-offset);

  // Work out the state after the command at the head of the queue.
  // All twelve columns move together, so a scroll step shifts the whole frame.
  always_comb begin
    digit_next  = digit;
    offset_next = offset;
    src_digit   = digit;
    row         = '0;
    for (int c = 0; c < COLUMNS; c++) begin
      frame_next[c] = frame[c];
    end
    case (cmd.op)
      OP_DOWN: begin
        // Feed the next digit in at the top, or the current one when the
        // frame is still scrolled up.
        src_digit = (offset > 0) ? digit : inc_digit;
        row       = neg_offset[ROW_W-1:0];
        for (int c = 0; c < COLUMNS; c++) begin
          frame_next[c] = {glyph_bit(src_digit, c, row), frame[c][ROWS-1:1]};
        end
        if (offset == -OFFSET_W'(ROWS - 1)) begin
          offset_next = '0;
          digit_next  = inc_digit;
        end else begin
          offset_next = OFFSET_W'(offset - 1'b1);
        end
      end
      OP_UP: begin
        // Feed the previous digit in at the bottom, or the current one
        // when the frame is still scrolled down.
        src_digit = (offset < 0) ? digit : dec_digit;
        row       = ROW_W'(ROWS - 1) - offset[ROW_W-1:0];
        for (int c = 0; c < COLUMNS; c++) begin
          frame_next[c] = {frame[c][ROWS-2:0], glyph_bit(src_digit, c, row)};
        end
        if (offset == OFFSET_W'(ROWS - 1)) begin
          offset_next = '0;
          digit_next  = dec_digit;
        end else begin
          offset_next = OFFSET_W'(offset + 1'b1);
        end
      end
      OP_SET: begin
        digit_next  = cmd.digit;
        offset_next = '0;
        for (int c = 0; c < COLUMNS; c++) begin
          frame_next[c] = glyph_word(cmd.digit, c);
        end
      end
      default: begin
      end
    endcase
  end

  // Frame, digit and offset registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      digit  <= '0;
      offset <= '0;
      for (int c = 0; c < COLUMNS; c++) begin
        frame[c] <= GLYPH_ROM[0][c];
      end
    end else if (take) begin
      digit  <= digit_next;
      offset <= offset_next;
      for (int c = 0; c < COLUMNS; c++) begin
        frame[c] <= frame_next[c];
      end
    end
  end

  // Output register and the column sweep of a read.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
      col_cnt   <= '0;
    end else if (take) begin
      out_valid <= 1'b1;
      if (cmd.op == OP_READ) begin
        busy    <= 1'b1;
        col_cnt <= COL_W'(1);
      end
    end else if (busy && out_free) begin
      out_valid <= 1'b1;
      col_cnt   <= COL_W'(col_cnt + 1'b1);
      if (col_cnt == LAST_COL) begin
        busy <= 1'b0;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload carries no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      if (cmd.op == OP_READ) begin
        out_col    <= '0;
        out_pix    <= frame[0];
        out_digit  <= digit;
        out_offset <= offset;
        out_last   <= 1'b0;
      end else begin
        out_col    <= '0;
        out_pix    <= '0;
        out_digit  <= digit_next;
        out_offset <= offset_next;
        out_last   <= 1'b1;
      end
    end else if (busy && out_free) begin
      out_col  <= col_cnt;
      out_pix  <= frame[col_cnt];
      out_last <= (col_cnt == LAST_COL);
    end
  end

  // A read starts its sweep with column zero in the very next cycle.
  a_read_start: assert property (@(posedge clk) disable iff (rst)
    take && cmd.op == OP_READ |=> busy && out_valid && out_col == '0 && !out_last)
    else $error("read did not start with column zero");

  // No word in the middle of a sweep is flagged as the final one.
  a_sweep_last: assert property (@(posedge clk) disable iff (rst)
    busy && out_valid |-> !out_last && out_col < LAST_COL)
    else $error("final flag raised during column sweep");

  // The shown state cannot move while a sweep is under way.
  a_sweep_stable: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(digit) && $stable(offset) && $stable(frame[0]))
    else $error("state changed during column sweep");

  // The offset wraps before it reaches a full glyph height and the digit stays in range.
  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    offset != -OFFSET_W'(ROWS) && digit <= LAST_DIGIT)
    else $error("offset or digit out of range");

endmodule

[sv/rolling_digit_scroller.sv]
// Rolling digit scroller: an odometer-style roller for a 12 by 16 dot frame.
// Requests arrive on the s_ channel: s_tuser holds the function (scroll, set
// or read), s_tdata the scroll direction and the digit to load. Results
// leave on the m_ channel: m_tdata holds the column number, the 16 dots of
// the column, the digit shown and the signed line offset; m_tlast marks the
// final result of a request.
// Scroll, set and unused function codes give one status result each; a read
// gives twelve column words, column zero first.
// A request enters a two-entry queue; the back end takes it from there and
// registers its first result in the output register. Scroll and set
// requests sustain one per cycle while m_tready is high and no read is
// under way, as all twelve columns shift together. A read holds the back
// end until all twelve column words have passed the output register.
// Reset empties the queue and the output register and shows digit zero at
// offset zero. When m_tready is low the output register holds its result,
// the queue fills, and s_tready falls once both queue entries are taken.
module rolling_digit_scroller
  import rds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [0] direction, [4:1] digit, [7:5] zero
  input  logic [1:0]  s_tuser,  // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // [3:0] column_index, [19:4] column_pixels,
                                // [23:20] shown_digit, [28:24] line_offset,
                                // [31:29] zero
  output logic        m_tlast
);

  logic                cmd_valid;
  logic                cmd_ready;
  cmd_t                cmd;
  logic [COL_W-1:0]    out_col;
  logic [ROWS-1:0]     out_pix;
  logic [DIGIT_W-1:0]  out_digit;
  logic [OFFSET_W-1:0] out_offset;

  // Request decode and queue.
  rds_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_func      (s_tuser),
    .in_direction (s_tdata[0]),
    .in_digit     (s_tdata[4:1]),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd)
  );

  // Frame state and result generation.
  rds_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_col    (out_col),
    .out_pix    (out_pix),
    .out_digit  (out_digit),
    .out_offset (out_offset),
    .out_last   (m_tlast)
  );

  // Pack the result fields, lowest first.
  assign m_tdata = {3'b000, out_offset, out_digit, out_pix, out_col};

endmodule
